@@ design/rdt_pkg.sv @@
// ----------------------------------------------------------------------------
// rdt_pkg
// shared widths, codes and types of the receiver session block
// ----------------------------------------------------------------------------
package rdt_pkg;

  // field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned CID_W    = 16;
  localparam int unsigned RKIND_W  = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned PROG_W   = 20;
  localparam int unsigned IDLE_W   = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RTX_INTERVAL = 2'd1;
  localparam logic [PROG_W-1:0] PROG_TIMEOUT_RST = 20'd10000;
  localparam logic [IDLE_W-1:0] RTX_INTERVAL_RST = 16'd250;

  // operation codes
  localparam logic [OP_W-1:0] OP_HEADER = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP   = 2'd2;

  // received header kinds
  localparam logic [KIND_W-1:0] KIND_SYN   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DATA  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIN   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OTHER = 3'd4;

  // reply kinds
  localparam logic [RKIND_W-1:0] REPLY_SYNACK = 2'd0;
  localparam logic [RKIND_W-1:0] REPLY_ACK    = 2'd1;
  localparam logic [RKIND_W-1:0] REPLY_FINACK = 2'd2;

  // exit status
  localparam logic [STATUS_W-1:0] ST_CLEAN   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STOP    = 2'd2;

  // session phases
  localparam logic [PHASE_W-1:0] PH_LISTEN      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HANDSHAKE   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ESTABLISHED = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LASTACK     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE        = 3'd4;

  // queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_TICK,
    CMD_STOP,
    CMD_NOP
  } cmd_e;

  // classified item as queued for the back end
  typedef struct packed {
    cmd_e              cmd;
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  seq_p1;
    logic [SEQ_W-1:0]  ack;
    logic [CID_W-1:0]  conn_id;
    logic [CID_W-1:0]  new_conn_id;
    logic [SEQ_W-1:0]  new_seq;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ design/rdt_if.sv @@
// ----------------------------------------------------------------------------
// rdt channel interfaces
// input item, result item and configuration write channels
// ----------------------------------------------------------------------------
interface rdt_in_if;
  import rdt_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [KIND_W-1:0] pkt_kind;
  logic [SEQ_W-1:0]  pkt_seq;
  logic [SEQ_W-1:0]  pkt_ack;
  logic [CID_W-1:0]  pkt_conn_id;
  logic [CID_W-1:0]  new_conn_id;
  logic [SEQ_W-1:0]  new_seq;

  modport source (
    output valid, operation, pkt_kind, pkt_seq, pkt_ack, pkt_conn_id, new_conn_id,
           new_seq,
    input  ready
  );
  modport sink (
    input  valid, operation, pkt_kind, pkt_seq, pkt_ack, pkt_conn_id, new_conn_id,
           new_seq,
    output ready
  );
endinterface

interface rdt_out_if;
  import rdt_pkg::*;
  logic                valid;
  logic                ready;
  logic                send_valid;
  logic [RKIND_W-1:0]  send_kind;
  logic [SEQ_W-1:0]    send_seq;
  logic [SEQ_W-1:0]    send_ack;
  logic [CID_W-1:0]    send_conn_id;
  logic                deliver_payload;
  logic                session_done;
  logic [STATUS_W-1:0] exit_status;
  logic [PHASE_W-1:0]  phase;

  modport source (
    output valid, send_valid, send_kind, send_seq, send_ack, send_conn_id,
           deliver_payload, session_done, exit_status, phase,
    input  ready
  );
  modport sink (
    input  valid, send_valid, send_kind, send_seq, send_ack, send_conn_id,
           deliver_payload, session_done, exit_status, phase,
    output ready
  );
endinterface

interface rdt_cfg_if;
  import rdt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/rdt_receiver_session_fsm_top.sv @@
// ----------------------------------------------------------------------------
// rdt_receiver_session_fsm_top
// receiver side of a reliable transfer session with three-way handshake
// ----------------------------------------------------------------------------
// Each input transaction is one decoded header, one millisecond tick or a
// stop request, and each one yields exactly one result transaction that shows
// the reply header to send (if any), whether a DATA payload is delivered, and
// the session phase and exit status after the item. The block takes one item
// per clock cycle when the result side keeps up; a result passes through the
// front queue and then the result register before it is presented. The rate
// is set by the back end, which updates the whole session state at once for
// each item. When results are not taken, the two-entry queue fills and
// in_i.ready drops once both entries are held. Configuration writes
// are always accepted (cfg_i.ready is tied high) and are meant to happen while
// no item is in flight; writes to an index beyond the two registers are taken
// and dropped. Session state and configuration come out of reset directly,
// with no clearing pass.
module rdt_receiver_session_fsm_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  rdt_in_if.sink    in_i,
  rdt_cfg_if.sink   cfg_i,
  rdt_out_if.source out_o
);
  import rdt_pkg::*;

  // front to queue
  logic      push;
  item_t     push_item;
  // queue to back
  logic      pop;
  item_t     pop_item;
  q_status_t q_status;

  // decode operation and kind, precompute the sequence successor
  rdt_front u_front (
    .in_i        (in_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // decouples acceptance from result back-pressure
  rdt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .q_status_o  (q_status)
  );

  // session state machine, timers and result register
  rdt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .item_i     (pop_item),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

@@ design/rdt_front.sv @@
// ----------------------------------------------------------------------------
// rdt_front
// accepts input transactions and classifies them for the back end
// ----------------------------------------------------------------------------
module rdt_front (
  rdt_in_if.sink            in_i,
  input  rdt_pkg::q_status_t q_status_i,
  output logic              push_o,
  output rdt_pkg::item_t    push_item_o
);
  import rdt_pkg::*;

  cmd_e              cmd;
  logic [KIND_W-1:0] kind;

  assign in_i.ready = !q_status_i.full;
  assign push_o     = in_i.valid && !q_status_i.full;

  always_comb begin
    case (in_i.operation)
      OP_HEADER: cmd = CMD_HDR;
      OP_TICK:   cmd = CMD_TICK;
      OP_STOP:   cmd = CMD_STOP;
      default:   cmd = CMD_NOP;
    endcase
  end

  // all flag combinations outside the known four fold into one code
  always_comb begin
    case (in_i.pkt_kind)
      KIND_SYN:  kind = KIND_SYN;
      KIND_ACK:  kind = KIND_ACK;
      KIND_DATA: kind = KIND_DATA;
      KIND_FIN:  kind = KIND_FIN;
      default:   kind = KIND_OTHER;
    endcase
  end

  always_comb begin
    push_item_o.cmd         = cmd;
    push_item_o.kind        = kind;
    push_item_o.seq         = in_i.pkt_seq;
    push_item_o.seq_p1      = in_i.pkt_seq + 1'b1;
    push_item_o.ack         = in_i.pkt_ack;
    push_item_o.conn_id     = in_i.pkt_conn_id;
    push_item_o.new_conn_id = in_i.new_conn_id;
    push_item_o.new_seq     = in_i.new_seq;
  end

endmodule

@@ design/rdt_fifo.sv @@
// ----------------------------------------------------------------------------
// rdt_fifo
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module rdt_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rdt_pkg::item_t     push_item_i,
  input  logic               pop_i,
  output rdt_pkg::item_t     pop_item_o,
  output rdt_pkg::q_status_t q_status_o
);
  import rdt_pkg::*;

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    logic [FIFO_PTR_W-1:0] r;
    if (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign q_status_o.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign q_status_o.empty = (count_q == '0);
  assign pop_item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ design/rdt_back.sv @@
// ----------------------------------------------------------------------------
// rdt_back
// session state machine, timers, configuration and result register
// ----------------------------------------------------------------------------
module rdt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  rdt_cfg_if.sink            cfg_i,
  input  rdt_pkg::item_t     item_i,
  input  rdt_pkg::q_status_t q_status_i,
  output logic               pop_o,
  rdt_out_if.source          out_o
);
  import rdt_pkg::*;

  // configuration
  logic [PROG_W-1:0] prog_timeout_q;
  logic [IDLE_W-1:0] rtx_interval_q;

  // session state
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic [CID_W-1:0]    conn_q, conn_d;
  logic [SEQ_W-1:0]    seq_q, seq_d;
  logic [SEQ_W-1:0]    ack_q, ack_d;
  logic [PROG_W-1:0]   prog_q, prog_d;
  logic [IDLE_W-1:0]   idle_q, idle_d;
  logic [STATUS_W-1:0] status_q, status_d;

  // result register
  logic                out_valid_q;
  logic                tx_valid_q, tx_valid;
  logic [RKIND_W-1:0]  tx_kind_q, tx_kind;
  logic [SEQ_W-1:0]    tx_seq_q;
  logic [SEQ_W-1:0]    tx_ack_q;
  logic [CID_W-1:0]    tx_cid_q;
  logic                deliver_q, deliver;

  logic              cid_ok;
  logic [SEQ_W-1:0]  own_seq_p1;
  logic              final_ack_ok;
  logic [PROG_W-1:0] prog_inc;
  logic [IDLE_W-1:0] idle_inc;

  assign cfg_i.ready = 1'b1;
  assign pop_o       = !q_status_i.empty && (!out_valid_q || out_o.ready);

  assign cid_ok       = (item_i.conn_id == conn_q);
  assign own_seq_p1   = seq_q + 1'b1;
  assign final_ack_ok = cid_ok && (item_i.ack == own_seq_p1) && (item_i.seq == ack_q);
  assign prog_inc     = (prog_q == '1) ? prog_q : prog_q + 1'b1;
  assign idle_inc     = (idle_q == '1) ? idle_q : idle_q + 1'b1;

  always_comb begin
    phase_d  = phase_q;
    conn_d   = conn_q;
    seq_d    = seq_q;
    ack_d    = ack_q;
    prog_d   = prog_q;
    idle_d   = idle_q;
    status_d = status_q;
    tx_valid = 1'b0;
    tx_kind  = REPLY_SYNACK;
    deliver  = 1'b0;
    if (phase_q != PH_DONE) begin
      case (item_i.cmd)
        CMD_HDR: begin
          idle_d = '0;
          case (phase_q)
            PH_LISTEN: begin
              if (item_i.kind == KIND_SYN) begin
                conn_d   = item_i.new_conn_id;
                seq_d    = item_i.new_seq;
                ack_d    = item_i.seq_p1;
                tx_valid = 1'b1;
                tx_kind  = REPLY_SYNACK;
                prog_d   = '0;
                phase_d  = PH_HANDSHAKE;
              end
            end
            PH_HANDSHAKE: begin
              if (item_i.kind == KIND_SYN && item_i.seq_p1 == ack_q) begin
                tx_valid = 1'b1;
                tx_kind  = REPLY_SYNACK;
              end else if ((item_i.kind == KIND_ACK || item_i.kind == KIND_DATA)
                           && final_ack_ok) begin
                prog_d  = '0;
                phase_d = PH_ESTABLISHED;
              end
            end
            PH_ESTABLISHED: begin
              if (item_i.kind == KIND_FIN && cid_ok && item_i.seq == ack_q) begin
                ack_d    = item_i.seq_p1;
                tx_valid = 1'b1;
                tx_kind  = REPLY_FINACK;
                prog_d   = '0;
                phase_d  = PH_LASTACK;
              end else if (item_i.kind == KIND_DATA && cid_ok) begin
                // in order: deliver and advance, ahead: only counts as progress
                if (item_i.seq == ack_q) begin
                  deliver = 1'b1;
                  ack_d   = item_i.seq_p1;
                  prog_d  = '0;
                end else if (item_i.seq > ack_q) begin
                  prog_d = '0;
                end
                tx_valid = 1'b1;
                tx_kind  = REPLY_ACK;
              end
            end
            PH_LASTACK: begin
              if (item_i.kind == KIND_FIN && cid_ok && item_i.seq_p1 == ack_q) begin
                tx_valid = 1'b1;
                tx_kind  = REPLY_FINACK;
              end else if (item_i.kind == KIND_ACK && final_ack_ok) begin
                prog_d   = '0;
                phase_d  = PH_DONE;
                status_d = ST_CLEAN;
              end
            end
            default: begin
            end
          endcase
        end
        CMD_TICK: begin
          prog_d = prog_inc;
          idle_d = idle_inc;
          if (prog_inc >= prog_timeout_q) begin
            phase_d  = PH_DONE;
            status_d = (phase_q == PH_LASTACK) ? ST_CLEAN : ST_TIMEOUT;
          end else if (phase_q == PH_LASTACK && idle_inc >= rtx_interval_q) begin
            tx_valid = 1'b1;
            tx_kind  = REPLY_FINACK;
            idle_d   = '0;
          end
        end
        CMD_STOP: begin
          phase_d  = PH_DONE;
          status_d = ST_STOP;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_timeout_q <= PROG_TIMEOUT_RST;
      rtx_interval_q <= RTX_INTERVAL_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_PROG_TIMEOUT) begin
        prog_timeout_q <= cfg_i.data[PROG_W-1:0];
      end else if (cfg_i.index == CFG_RTX_INTERVAL) begin
        rtx_interval_q <= cfg_i.data[IDLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LISTEN;
      conn_q   <= '0;
      seq_q    <= '0;
      ack_q    <= '0;
      prog_q   <= '0;
      idle_q   <= '0;
      status_q <= ST_CLEAN;
    end else if (pop_o) begin
      phase_q  <= phase_d;
      conn_q   <= conn_d;
      seq_q    <= seq_d;
      ack_q    <= ack_d;
      prog_q   <= prog_d;
      idle_q   <= idle_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tx_valid_q <= tx_valid;
      tx_kind_q  <= tx_valid ? tx_kind : '0;
      tx_seq_q   <= tx_valid ? seq_d : '0;
      tx_ack_q   <= tx_valid ? ack_d : '0;
      tx_cid_q   <= tx_valid ? conn_d : '0;
      deliver_q  <= deliver;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.send_valid      = tx_valid_q;
  assign out_o.send_kind       = tx_kind_q;
  assign out_o.send_seq        = tx_seq_q;
  assign out_o.send_ack        = tx_ack_q;
  assign out_o.send_conn_id    = tx_cid_q;
  assign out_o.deliver_payload = deliver_q;
  assign out_o.session_done    = (phase_q == PH_DONE);
  assign out_o.exit_status     = status_q;
  assign out_o.phase           = phase_q;

endmodule

@@ design/rdt_checker.sv @@
// ----------------------------------------------------------------------------
// rdt_checker
// port-level checks of the receiver session block, bound to the top level
// ----------------------------------------------------------------------------
module rdt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         send_valid_i,
  input logic [rdt_pkg::RKIND_W-1:0]  send_kind_i,
  input logic [rdt_pkg::SEQ_W-1:0]    send_seq_i,
  input logic                         deliver_payload_i,
  input logic                         session_done_i,
  input logic [rdt_pkg::PHASE_W-1:0]  phase_i
);
  import rdt_pkg::*;

  logic done_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_seen_q <= 1'b0;
    end else if (out_valid_i && out_ready_i && session_done_i) begin
      done_seen_q <= 1'b1;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(send_valid_i)
      && $stable(send_seq_i) && $stable(phase_i))
    else $error("result changed while stalled");

  // once ended, the session stays ended
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_seen_q |-> session_done_i && phase_i == PH_DONE)
    else $error("session left done phase");

  a_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> session_done_i == (phase_i == PH_DONE))
    else $error("session_done disagrees with phase");

  // a delivered payload is always acknowledged
  a_deliver_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && deliver_payload_i |-> send_valid_i && send_kind_i == REPLY_ACK
      && phase_i == PH_ESTABLISHED)
    else $error("delivery without ack");

endmodule

bind rdt_receiver_session_fsm_top rdt_checker u_rdt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .send_valid_i      (out_o.send_valid),
  .send_kind_i       (out_o.send_kind),
  .send_seq_i        (out_o.send_seq),
  .deliver_payload_i (out_o.deliver_payload),
  .session_done_i    (out_o.session_done),
  .phase_i           (out_o.phase)
);

@@ dv/tb_rdt_receiver_session_fsm_top.sv @@
// ----------------------------------------------------------------------------
// tb_rdt_receiver_session_fsm_top
// self-checking bench for the receiver session block: one session is walked
// from listen through handshake, data transfer and, in most runs, last-ack to
// its close while a transaction-level model of the session predicts every
// result transaction
module tb_rdt_receiver_session_fsm_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rdt_pkg::*;

  // codes the package leaves out: spare operation and spare register index
  localparam logic [OP_W-1:0]      OP_SPARE      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int unsigned          STALL_LIMIT   = 2000;

  // how the session is brought to its end in this run
  typedef enum int {
    END_FINAL_ACK,
    END_LASTACK_TIMEOUT,
    END_LASTACK_STOP,
    END_EST_TIMEOUT,
    END_EST_STOP
  } close_mode_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [KIND_W-1:0] pkt_kind;
    logic [SEQ_W-1:0]  pkt_seq;
    logic [SEQ_W-1:0]  pkt_ack;
    logic [CID_W-1:0]  pkt_conn_id;
    logic [CID_W-1:0]  new_conn_id;
    logic [SEQ_W-1:0]  new_seq;
  } rx_item_t;

  typedef struct packed {
    logic                send_valid;
    logic [RKIND_W-1:0]  send_kind;
    logic [SEQ_W-1:0]    send_seq;
    logic [SEQ_W-1:0]    send_ack;
    logic [CID_W-1:0]    send_conn_id;
    logic                deliver_payload;
    logic                session_done;
    logic [STATUS_W-1:0] exit_status;
    logic [PHASE_W-1:0]  phase;
  } session_result_t;

  logic clk_i;
  logic rst_ni;

  rdt_in_if  in_if ();
  rdt_cfg_if cfg_if ();
  rdt_out_if out_if ();

  rdt_receiver_session_fsm_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // --------------------------------------------------------------------------
  // session model: state, configuration and the queue of predicted results
  // --------------------------------------------------------------------------
  logic [PHASE_W-1:0]  ph_q;
  logic [CID_W-1:0]    cid_q;
  logic [SEQ_W-1:0]    own_seq_q;
  logic [SEQ_W-1:0]    rcv_next_q;
  logic [PROG_W-1:0]   no_progress_ms;
  logic [IDLE_W-1:0]   rx_quiet_ms;
  logic [STATUS_W-1:0] close_status_q;
  logic [PROG_W-1:0]   timeout_limit_ms;
  logic [IDLE_W-1:0]   resend_after_ms;

  session_result_t session_outcomes[$];

  int          fail_count  = 0;
  int          stall_left  = 0;
  int unsigned idle_cycles = 0;
  bit          gaps_on     = 1'b1;
  bit          gaps_locked = 1'b0;
  close_mode_e close_mode;

  // one transaction into the session, returns what the block must report
  function automatic session_result_t advance_session(input rx_item_t it);
    session_result_t    r;
    logic               tx_en;
    logic [RKIND_W-1:0] tx_kind;
    logic               dlv;
    logic               cid_ok;
    logic [SEQ_W-1:0]   pkt_seq_p1;
    logic [SEQ_W-1:0]   own_seq_p1;
    r          = '0;
    tx_en      = 1'b0;
    tx_kind    = REPLY_SYNACK;
    dlv        = 1'b0;
    cid_ok     = (it.pkt_conn_id == cid_q);
    pkt_seq_p1 = it.pkt_seq + 32'd1;
    own_seq_p1 = own_seq_q + 32'd1;
    if (ph_q != PH_DONE) begin
      case (it.operation)
        OP_HEADER: begin
          // any header at all restarts the quiet timer
          rx_quiet_ms = '0;
          case (ph_q)
            PH_LISTEN: begin
              if (it.pkt_kind == KIND_SYN) begin
                cid_q          = it.new_conn_id;
                own_seq_q      = it.new_seq;
                rcv_next_q     = pkt_seq_p1;
                tx_en          = 1'b1;
                tx_kind        = REPLY_SYNACK;
                no_progress_ms = '0;
                ph_q           = PH_HANDSHAKE;
              end
            end
            PH_HANDSHAKE: begin
              if (it.pkt_kind == KIND_SYN && pkt_seq_p1 == rcv_next_q) begin
                tx_en   = 1'b1;
                tx_kind = REPLY_SYNACK;
              end else if ((it.pkt_kind == KIND_ACK || it.pkt_kind == KIND_DATA) &&
                           cid_ok && it.pkt_ack == own_seq_p1 &&
                           it.pkt_seq == rcv_next_q) begin
                no_progress_ms = '0;
                ph_q           = PH_ESTABLISHED;
              end
            end
            PH_ESTABLISHED: begin
              if (it.pkt_kind == KIND_FIN && cid_ok && it.pkt_seq == rcv_next_q) begin
                rcv_next_q     = pkt_seq_p1;
                tx_en          = 1'b1;
                tx_kind        = REPLY_FINACK;
                no_progress_ms = '0;
                ph_q           = PH_LASTACK;
              end else if (it.pkt_kind == KIND_DATA && cid_ok) begin
                if (it.pkt_seq == rcv_next_q) begin
                  dlv            = 1'b1;
                  rcv_next_q     = rcv_next_q + 32'd1;
                  no_progress_ms = '0;
                end else if (it.pkt_seq > rcv_next_q) begin
                  no_progress_ms = '0;
                end
                tx_en   = 1'b1;
                tx_kind = REPLY_ACK;
              end
            end
            PH_LASTACK: begin
              if (it.pkt_kind == KIND_FIN && cid_ok && pkt_seq_p1 == rcv_next_q) begin
                tx_en   = 1'b1;
                tx_kind = REPLY_FINACK;
              end else if (it.pkt_kind == KIND_ACK && cid_ok &&
                           it.pkt_ack == own_seq_p1 && it.pkt_seq == rcv_next_q) begin
                no_progress_ms = '0;
                close_status_q = ST_CLEAN;
                ph_q           = PH_DONE;
              end
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          if (no_progress_ms != '1) no_progress_ms = no_progress_ms + 1'b1;
          if (rx_quiet_ms != '1) rx_quiet_ms = rx_quiet_ms + 1'b1;
          if (no_progress_ms >= timeout_limit_ms) begin
            close_status_q = (ph_q == PH_LASTACK) ? ST_CLEAN : ST_TIMEOUT;
            ph_q           = PH_DONE;
          end else if (ph_q == PH_LASTACK && rx_quiet_ms >= resend_after_ms) begin
            tx_en       = 1'b1;
            tx_kind     = REPLY_FINACK;
            rx_quiet_ms = '0;
          end
        end
        OP_STOP: begin
          close_status_q = ST_STOP;
          ph_q           = PH_DONE;
        end
        default: ;
      endcase
    end
    r.send_valid = tx_en;
    if (tx_en) begin
      r.send_kind    = tx_kind;
      r.send_seq     = own_seq_q;
      r.send_ack     = rcv_next_q;
      r.send_conn_id = cid_q;
    end
    r.deliver_payload = dlv;
    r.session_done    = (ph_q == PH_DONE);
    r.exit_status     = close_status_q;
    r.phase           = ph_q;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // mostly back to back, some short gaps, a rare long one
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 98) return $urandom_range(4, 12);
    else return $urandom_range(20, 50);
  endfunction

  function automatic logic [SEQ_W-1:0] pick_edge32();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // every field random, operation as given
  function automatic rx_item_t random_item(input logic [OP_W-1:0] op);
    rx_item_t it;
    it.operation   = op;
    it.pkt_kind    = KIND_W'($urandom_range(0, 7));
    it.pkt_seq     = $urandom;
    it.pkt_ack     = $urandom;
    it.pkt_conn_id = CID_W'($urandom_range(0, 65535));
    it.new_conn_id = CID_W'($urandom_range(1, 60000));
    it.new_seq     = $urandom;
    return it;
  endfunction

  function automatic rx_item_t header_item(input logic [KIND_W-1:0] kind,
                                           input logic [SEQ_W-1:0] seq,
                                           input logic [SEQ_W-1:0] ack,
                                           input logic [CID_W-1:0] cid);
    rx_item_t it;
    it             = random_item(OP_HEADER);
    it.pkt_kind    = kind;
    it.pkt_seq     = seq;
    it.pkt_ack     = ack;
    it.pkt_conn_id = cid;
    return it;
  endfunction

  // in-order data above all, with old, future, foreign, garbage and tick items mixed in
  function automatic rx_item_t pick_established_item();
    rx_item_t it;
    int       r;
    it = random_item(OP_HEADER);
    r  = $urandom_range(0, 99);
    if (r < 40)
      it = header_item(KIND_DATA, rcv_next_q, own_seq_q + 32'd1, cid_q);
    else if (r < 50)
      it = header_item(KIND_DATA, rcv_next_q - $urandom_range(1, 4), $urandom, cid_q);
    else if (r < 58)
      it = header_item(KIND_DATA, rcv_next_q + $urandom_range(1, 1000), $urandom, cid_q);
    else if (r < 63)
      it = header_item(KIND_DATA, $urandom, $urandom, cid_q);
    else if (r < 68)
      it = header_item(KIND_DATA, rcv_next_q, $urandom,
                       cid_q ^ (16'd1 << $urandom_range(0, 15)));
    else if (r < 83)
      it.operation = OP_TICK;
    else if (r < 95 && r >= 93)
      it.operation = OP_SPARE;
    else if (r >= 95)
      it = header_item(KIND_FIN, rcv_next_q + $urandom_range(1, 9), $urandom, cid_q);
    return it;
  endfunction

  // one input transaction; valid stays up when the next one follows directly
  task automatic send_item(input rx_item_t it);
    int gap;
    gap = pick_gap();
    if (!gaps_locked && $urandom_range(0, 99) == 0) gaps_on = !gaps_on;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= it.operation;
    in_if.pkt_kind    <= it.pkt_kind;
    in_if.pkt_seq     <= it.pkt_seq;
    in_if.pkt_ack     <= it.pkt_ack;
    in_if.pkt_conn_id <= it.pkt_conn_id;
    in_if.new_conn_id <= it.new_conn_id;
    in_if.new_seq     <= it.new_seq;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    session_outcomes.push_back(advance_session(it));
  endtask

  // register write, only once the pipe has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_if.valid <= 1'b0;
    while (session_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_PROG_TIMEOUT: timeout_limit_ms = data[PROG_W-1:0];
      CFG_RTX_INTERVAL: resend_after_ms  = data[IDLE_W-1:0];
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // listen ignores everything but SYN; ticks still count toward the timeout
  task automatic test_listen();
    rx_item_t it;
    repeat (2) send_item(random_item(OP_TICK));
    for (int k = 1; k < 8; k++) begin
      it          = random_item(OP_HEADER);
      it.pkt_kind = KIND_W'(k);
      send_item(it);
    end
    send_item(random_item(OP_SPARE));
    // spare index must be swallowed without effect
    write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
    write_reg(CFG_PROG_TIMEOUT, 20'd1000000);
    write_reg(CFG_RTX_INTERVAL, {4'($urandom_range(1, 15)), 16'd250});
  endtask

  // SYN with edge values, SYN+ACK resend, near misses, then the opening
  task automatic test_handshake();
    rx_item_t it;
    it = header_item(KIND_SYN, pick_edge32(), $urandom, CID_W'($urandom_range(0, 65535)));
    case ($urandom_range(0, 2))
      0:       it.new_conn_id = 16'd1;
      1:       it.new_conn_id = 16'd60000;
      default: it.new_conn_id = CID_W'($urandom_range(1, 60000));
    endcase
    it.new_seq = pick_edge32();
    send_item(it);
    send_item(header_item(KIND_SYN, rcv_next_q - 32'd1, $urandom,
                          CID_W'($urandom_range(0, 65535))));
    send_item(header_item(KIND_SYN, rcv_next_q, $urandom, cid_q));
    send_item(header_item(KIND_ACK, rcv_next_q, own_seq_q + 32'd1, cid_q ^ 16'h8000));
    send_item(header_item(KIND_ACK, rcv_next_q, own_seq_q, cid_q));
    send_item(header_item(KIND_DATA, rcv_next_q + 32'd1, own_seq_q + 32'd1, cid_q));
    send_item(random_item(OP_TICK));
    send_item(header_item(KIND_FIN, rcv_next_q, own_seq_q + 32'd1, cid_q));
    send_item(header_item(KIND_OTHER, rcv_next_q, own_seq_q + 32'd1, cid_q));
    // the final ACK or a matching DATA opens the session
    send_item(header_item($urandom_range(0, 1) ? KIND_ACK : KIND_DATA,
                          rcv_next_q, own_seq_q + 32'd1, cid_q));
  endtask

  task automatic test_data_directed();
    send_item(header_item(KIND_DATA, rcv_next_q, own_seq_q + 32'd1, cid_q));
    send_item(header_item(KIND_DATA, rcv_next_q - 32'd1, own_seq_q + 32'd1, cid_q));
    send_item(header_item(KIND_DATA, rcv_next_q + 32'd5, own_seq_q + 32'd1, cid_q));
    send_item(header_item(KIND_DATA, rcv_next_q, own_seq_q + 32'd1, cid_q + 16'd1));
    send_item(header_item(KIND_SYN, rcv_next_q - 32'd1, $urandom, cid_q));
    send_item(header_item(KIND_ACK, rcv_next_q, own_seq_q + 32'd1, cid_q));
    send_item(header_item(KIND_FIN, rcv_next_q + 32'd1, own_seq_q + 32'd1, cid_q));
    send_item(random_item(OP_TICK));
  endtask

  // long random data phase, settings changed between chunks
  task automatic test_data_random();
    for (int chunk = 0; chunk < 6; chunk++) begin
      write_reg(CFG_PROG_TIMEOUT,
                CFG_DATA_W'(($urandom_range(0, 3) == 0) ? 20'd1000000
                                                         : $urandom_range(60, 5000)));
      write_reg(CFG_RTX_INTERVAL, {4'($urandom_range(0, 15)), 16'($urandom_range(1, 65535))});
      repeat (150) send_item(pick_established_item());
    end
  endtask

  // FIN, FIN+ACK resends on duplicate FIN and on quiet time, near-miss ACKs
  task automatic test_last_ack();
    rx_item_t it;
    int       r;
    write_reg(CFG_PROG_TIMEOUT, 20'd1000000);
    write_reg(CFG_RTX_INTERVAL, 20'd1);
    send_item(header_item(KIND_FIN, rcv_next_q, own_seq_q + 32'd1, cid_q));
    send_item(header_item(KIND_FIN, rcv_next_q - 32'd1, $urandom, cid_q));
    send_item(header_item(KIND_FIN, rcv_next_q - 32'd1, $urandom, cid_q ^ 16'h0001));
    repeat (2) send_item(random_item(OP_TICK));
    send_item(header_item(KIND_ACK, rcv_next_q, own_seq_q + 32'd2, cid_q));
    send_item(header_item(KIND_ACK, rcv_next_q + 32'd1, own_seq_q + 32'd1, cid_q));
    send_item(header_item(KIND_DATA, rcv_next_q, own_seq_q + 32'd1, cid_q));
    send_item(random_item(OP_TICK));
    write_reg(CFG_RTX_INTERVAL, CFG_DATA_W'($urandom_range(2, 6)));
    repeat (150) begin
      r = $urandom_range(0, 99);
      if (r < 50)
        it = random_item(OP_TICK);
      else if (r < 60)
        it = header_item(KIND_FIN, rcv_next_q - 32'd1, $urandom, cid_q);
      else if (r < 75)
        it = header_item(KIND_ACK, rcv_next_q, own_seq_q + $urandom_range(2, 9), cid_q);
      else
        it = random_item(OP_HEADER);
      send_item(it);
    end
    // data bits above the register are dropped; an unbroken run of ticks
    // crosses the interval once
    write_reg(CFG_RTX_INTERVAL, 20'hA0020);
    gaps_locked = 1'b1;
    gaps_on     = 1'b0;
    send_item(random_item(OP_HEADER));
    repeat (40) send_item(random_item(OP_TICK));
    gaps_locked = 1'b0;
    gaps_on     = 1'b1;
  endtask

  task automatic test_close();
    case (close_mode)
      END_FINAL_ACK:
        send_item(header_item(KIND_ACK, rcv_next_q, own_seq_q + 32'd1, cid_q));
      END_LASTACK_TIMEOUT, END_EST_TIMEOUT: begin
        // a limit of zero or one ends on the very next tick
        write_reg(CFG_PROG_TIMEOUT, CFG_DATA_W'($urandom_range(0, 1)));
        send_item(random_item(OP_TICK));
      end
      default:
        send_item(random_item(OP_STOP));
    endcase
  endtask

  // once done, nothing moves any more
  task automatic test_done_ignored();
    repeat (12) send_item(random_item(OP_W'($urandom_range(0, 3))));
  endtask

  // --------------------------------------------------------------------------
  // clock, reset and stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    int r;
    ph_q             = PH_LISTEN;
    cid_q            = '0;
    own_seq_q        = '0;
    rcv_next_q       = '0;
    no_progress_ms   = '0;
    rx_quiet_ms      = '0;
    close_status_q   = ST_CLEAN;
    timeout_limit_ms = PROG_TIMEOUT_RST;
    resend_after_ms  = RTX_INTERVAL_RST;
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.operation    <= OP_HEADER;
    in_if.pkt_kind     <= KIND_SYN;
    in_if.pkt_seq      <= '0;
    in_if.pkt_ack      <= '0;
    in_if.pkt_conn_id  <= '0;
    in_if.new_conn_id  <= '0;
    in_if.new_seq      <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CFG_PROG_TIMEOUT;
    cfg_if.data        <= '0;
    r = $urandom_range(0, 9);
    if (r == 0) close_mode = END_EST_TIMEOUT;
    else if (r == 1) close_mode = END_EST_STOP;
    else close_mode = close_mode_e'($urandom_range(0, 2));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_listen();
    test_handshake();
    test_data_directed();
    test_data_random();
    if (close_mode != END_EST_TIMEOUT && close_mode != END_EST_STOP) test_last_ack();
    test_close();
    test_done_ignored();

    // drain, then keep watching for anything unexpected to show up
    in_if.valid <= 1'b0;
    while (session_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (session_outcomes.size() != 0) begin
      $error("%0d results never arrived", session_outcomes.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side: random back-pressure and field-by-field compare
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [SEQ_W-1:0] want,
                                      input logic [SEQ_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    session_result_t want;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (session_outcomes.size() == 0) begin
        $error("result transaction with no item outstanding");
        fail_count++;
      end else begin
        want = session_outcomes.pop_front();
        check_field("send_valid", SEQ_W'(want.send_valid), SEQ_W'(out_if.send_valid));
        check_field("send_kind", SEQ_W'(want.send_kind), SEQ_W'(out_if.send_kind));
        check_field("send_seq", want.send_seq, out_if.send_seq);
        check_field("send_ack", want.send_ack, out_if.send_ack);
        check_field("send_conn_id", SEQ_W'(want.send_conn_id), SEQ_W'(out_if.send_conn_id));
        check_field("deliver_payload", SEQ_W'(want.deliver_payload),
                    SEQ_W'(out_if.deliver_payload));
        check_field("session_done", SEQ_W'(want.session_done), SEQ_W'(out_if.session_done));
        check_field("exit_status", SEQ_W'(want.exit_status), SEQ_W'(out_if.exit_status));
        check_field("phase", SEQ_W'(want.phase), SEQ_W'(out_if.phase));
      end
    end
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // watchdog: too long without any transaction on any channel
  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
